FILE: rtl/lwd_pkg.sv
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types and constants for the lzss window decompressor: window
// geometry, result status codes and the command passed from parser to copier.
// ----------------------------------------------------------------------------
package lwd_pkg;

  // window geometry
  localparam int unsigned WinAw    = 12;
  localparam int unsigned WinDepth = 1 << WinAw;
  localparam logic [WinAw-1:0] StartPos = WinAw'(WinDepth - 16);

  // token encoding
  localparam logic [4:0] MinMatchLen = 5'd3;

  // result status codes
  localparam logic [1:0] StData    = 2'd0;
  localparam logic [1:0] StOverrun = 2'd1;
  localparam logic [1:0] StCutOff  = 2'd2;
  localparam logic [1:0] StEarly   = 2'd3;

  // command queue depth
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdAw    = $clog2(CmdDepth);

  // one classified request: a literal, a window copy and/or a trailing error
  typedef struct packed {
    logic             is_lit;  // addr[7:0] carries the literal byte
    logic [WinAw-1:0] addr;    // copy source position
    logic [4:0]       count;   // data bytes to produce, 0 to 18
    logic [1:0]       err;     // status of a trailing error result, or StData
  } cmd_t;

endpackage

FILE: rtl/lwd_parser.sv
// ----------------------------------------------------------------------------
// lwd_parser
// Front end: takes compressed bytes, tracks flag bits and match halves, and
// turns each request into at most one command for the copy engine. Keeps a
// projected output count so it can cut matches at the output size on its own.
// ----------------------------------------------------------------------------
module lwd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  input  logic [31:0]   size_i,
  input  logic          full_i,
  output logic          push_o,
  output lwd_pkg::cmd_t cmd_o
);
  import lwd_pkg::*;

  typedef enum logic {
    PH_TOKEN,
    PH_MATCH_HI
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [3:0]  left_q, left_d;
  logic [7:0]  off_lo_q, off_lo_d;
  logic [31:0] pc_q, pc_d;
  logic        fin_q, fin_d;

  logic        accept;
  logic        active;
  logic [31:0] avail;
  logic        avail_small;
  logic [4:0]  len;
  logic [4:0]  cnt;

  assign in_stall_o  = full_i;
  assign accept      = in_valid_i && !full_i;
  assign active      = accept && !fin_q && (pc_q < size_i);
  assign avail       = size_i - pc_q;
  assign avail_small = (avail[31:5] == 27'd0);
  assign len         = {1'b0, in_byte_i[3:0]} + MinMatchLen;

  // token decode
  always_comb begin
    phase_d  = phase_q;
    flags_d  = flags_q;
    left_d   = left_q;
    off_lo_d = off_lo_q;
    pc_d     = pc_q;
    fin_d    = fin_q;
    push_o   = 1'b0;
    cmd_o    = '0;
    cnt      = 5'd0;
    if (active) begin
      if (phase_q == PH_MATCH_HI) begin
        phase_d     = PH_TOKEN;
        cmd_o.addr  = {in_byte_i[7:4], off_lo_q};
        if (avail_small && (avail[4:0] < len)) begin
          cnt       = avail[4:0];
          cmd_o.err = StOverrun;
          fin_d     = 1'b1;
        end else begin
          cnt = len;
        end
        cmd_o.count = cnt;
        push_o      = 1'b1;
      end else if (left_q == 4'd0) begin
        flags_d = in_byte_i;
        left_d  = 4'd8;
        if (in_last_i) begin
          cmd_o.err = StEarly;
          push_o    = 1'b1;
          fin_d     = 1'b1;
        end
      end else begin
        flags_d = {1'b0, flags_q[7:1]};
        left_d  = left_q - 4'd1;
        if (flags_q[0]) begin
          cnt         = 5'd1;
          cmd_o.is_lit = 1'b1;
          cmd_o.addr  = {4'd0, in_byte_i};
          cmd_o.count = cnt;
          push_o      = 1'b1;
        end else if (in_last_i) begin
          cmd_o.err = StCutOff;
          push_o    = 1'b1;
          fin_d     = 1'b1;
        end else begin
          off_lo_d = in_byte_i;
          phase_d  = PH_MATCH_HI;
        end
      end
      // output complete or stream over
      pc_d = pc_q + {27'd0, cnt};
      if ((cnt != 5'd0) && avail_small && (avail[4:0] <= cnt)) begin
        fin_d = 1'b1;
      end
      if (in_last_i) begin
        fin_d = 1'b1;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TOKEN;
      flags_q  <= 8'd0;
      left_q   <= 4'd0;
      off_lo_q <= 8'd0;
      pc_q     <= 32'd0;
      fin_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      left_q   <= left_d;
      off_lo_q <= off_lo_d;
      pc_q     <= pc_d;
      fin_q    <= fin_d;
    end
  end

endmodule

FILE: rtl/lwd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lwd_cmd_fifo
// Short command queue between parser and copy engine.
// ----------------------------------------------------------------------------
module lwd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lwd_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lwd_pkg::cmd_t cmd_o
);
  import lwd_pkg::*;

  cmd_t             mem_q [CmdDepth];
  logic [CmdAw-1:0] wr_ptr_q;
  logic [CmdAw-1:0] rd_ptr_q;
  logic [CmdAw:0]   cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == (CmdAw+1)'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lwd_copy_engine.sv
// ----------------------------------------------------------------------------
// lwd_copy_engine
// Back end: carries out commands against the 4096-byte history window
// (a read and a write per copied byte, a write per literal) and drives the
// result register. Window entries not yet written read as zero by comparing
// against the running byte count, so the window needs no clearing pass.
// ----------------------------------------------------------------------------
module lwd_copy_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   size_i,
  input  logic          empty_i,
  input  lwd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic [1:0]    status_o,
  output logic          out_done_o,
  output logic          run_last_o
);
  import lwd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_ERROR
  } state_e;

  logic [7:0]       win_q [WinDepth];
  logic [7:0]       rdata_q;

  state_e           state_q;
  logic             lit_q;
  logic [WinAw-1:0] addr_q;
  logic [4:0]       rem_q;
  logic [1:0]       err_q;
  logic             hit_q;
  logic [WinAw-1:0] wp_q;
  logic [31:0]      bw_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic [1:0]       status_q;
  logic             out_done_q;
  logic             run_last_q;

  logic             slot_free;
  logic             emit_res;
  logic             win_we;
  logic [7:0]       wdata;
  logic [WinAw-1:0] rel_pos;
  logic             written;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit_res  = ((state_q == ST_WRITE) || (state_q == ST_ERROR)) && slot_free;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign win_we    = (state_q == ST_WRITE) && slot_free;
  assign wdata     = lit_q ? addr_q[7:0] : (hit_q ? rdata_q : 8'd0);

  // entry has been written once the fill count passes its distance from start
  assign rel_pos = addr_q - StartPos;
  assign written = (bw_q[31:WinAw] != '0) || ({20'd0, rel_pos} < bw_q);

  // history window
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_q[wp_q] <= wdata;
    end
    if (state_q == ST_READ) begin
      rdata_q <= win_q[addr_q];
    end
  end

  // copy sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lit_q       <= 1'b0;
      addr_q      <= '0;
      rem_q       <= 5'd0;
      err_q       <= StData;
      hit_q       <= 1'b0;
      wp_q        <= StartPos;
      bw_q        <= 32'd0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      status_q    <= StData;
      out_done_q  <= 1'b0;
      run_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !emit_res) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            lit_q  <= cmd_i.is_lit;
            addr_q <= cmd_i.addr;
            rem_q  <= cmd_i.count;
            err_q  <= cmd_i.err;
            if (cmd_i.count == 5'd0) begin
              state_q <= ST_ERROR;
            end else if (cmd_i.is_lit) begin
              state_q <= ST_WRITE;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          hit_q   <= written;
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= wdata;
            status_q    <= StData;
            out_done_q  <= ((bw_q + 32'd1) == size_i);
            run_last_q  <= (rem_q == 5'd1) && (err_q == StData);
            wp_q        <= wp_q + 1'b1;
            bw_q        <= bw_q + 32'd1;
            addr_q      <= addr_q + 1'b1;
            rem_q       <= rem_q - 5'd1;
            if (rem_q != 5'd1) begin
              state_q <= ST_READ;
            end else if (err_q != StData) begin
              state_q <= ST_ERROR;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_ERROR: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= 8'd0;
            status_q    <= err_q;
            out_done_q  <= 1'b0;
            run_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;
  assign out_done_o  = out_done_q;
  assign run_last_o  = run_last_q;

endmodule

FILE: rtl/lzss_window_decompressor_unit.sv
// Path: a literal passes the command queue and the copier's command registers to the result
// register; a match byte also passes the window read register. Copied bytes take one window
// read, then one window write on the single-port 4096x8 history memory; literals only write.
// The front runs ahead of the copier through a 2-entry command queue.
// Reset: control state clears at once; the window is not swept, entries not yet written
// read as zero, so requests are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
// lzss_window_decompressor_unit
// LZSS decompressor with a 4096-byte history window: parser front end,
// command queue and copy engine, plus the output size register.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  status_o,
  output logic        out_done_o,
  output logic        run_last_o
);
  import lwd_pkg::*;

  logic [31:0] size_q;
  logic        push;
  cmd_t        push_cmd;
  logic        full;
  logic        pop;
  logic        empty;
  cmd_t        head_cmd;

  // output size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 32'd0;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // front end
  lwd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .size_i     (size_q),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // command queue
  lwd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (head_cmd)
  );

  // back end
  lwd_copy_engine u_copy_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_i      (size_q),
    .empty_i     (empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .status_o    (status_o),
    .out_done_o  (out_done_o),
    .run_last_o  (run_last_o)
  );

endmodule
